// File: hdl/aabb_pkg.sv
// Shared constants and types for the bounding box and sphere accumulator.
package aabb_pkg;

  // Default coordinate width in bits (signed fixed point).
  localparam int COORD_BITS_DEF = 24;

  // Number of closed boxes that can wait between the front and back ends.
  localparam int QUEUE_DEPTH = 2;

  // Status of the box queue as seen by its producer and consumer.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: hdl/aabb_front.sv
// Front end: accepts items and keeps the running per-axis minima and maxima.
module aabb_front #(
  parameter int COORD_BITS = aabb_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic                         action,
  input  logic signed [COORD_BITS-1:0] lo [3],
  input  logic signed [COORD_BITS-1:0] hi [3],
  input  logic                         last_item,
  output logic                         q_push,
  output logic [6*COORD_BITS-1:0]      q_wdata
);

  logic signed [COORD_BITS-1:0] run_min [3];
  logic signed [COORD_BITS-1:0] run_max [3];
  logic signed [COORD_BITS-1:0] min_next [3];
  logic signed [COORD_BITS-1:0] max_next [3];
  logic signed [COORD_BITS-1:0] hi_eff [3];
  logic                         run_open;

  // A vertex supplies the same point for both corners; the first item of a
  // run loads the extremes, later items widen them.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      hi_eff[a]   = action ? hi[a] : lo[a];
      min_next[a] = (!run_open || (lo[a] < run_min[a])) ? lo[a] : run_min[a];
      max_next[a] = (!run_open || (hi_eff[a] > run_max[a])) ? hi_eff[a] : run_max[a];
    end
  end

  // The closing item hands the finished box to the queue.
  assign q_push = accept && last_item;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      q_wdata[a*COORD_BITS +: COORD_BITS]     = min_next[a];
      q_wdata[(a+3)*COORD_BITS +: COORD_BITS] = max_next[a];
    end
  end

  // Running extremes and the run-open flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_open <= 1'b0;
    end else if (accept) begin
      run_open <= !last_item;
    end
    if (accept) begin
      for (int a = 0; a < 3; a++) begin
        run_min[a] <= min_next[a];
        run_max[a] <= max_next[a];
      end
    end
  end

endmodule

// File: hdl/aabb_queue.sv
// Short register queue that holds closed boxes between front and back ends.
module aabb_queue #(
  parameter int WIDTH = 6 * aabb_pkg::COORD_BITS_DEF,
  parameter int DEPTH = aabb_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [WIDTH-1:0]      wdata,
  input  logic                  pop,
  output logic [WIDTH-1:0]      rdata,
  output aabb_pkg::q_stat_t     stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = entries[rd_ptr];

  // Pointers wrap at the queue depth; the count tracks occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

endmodule

// File: hdl/aabb_back.sv
// Back end: center, squared diagonal and bit-serial square root per box.
module aabb_back #(
  parameter int COORD_BITS = aabb_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  aabb_pkg::q_stat_t            q_stat,
  input  logic [6*COORD_BITS-1:0]      q_rdata,
  output logic                         q_pop,
  input  logic                         out_pop,
  output logic                         out_valid,
  output logic signed [COORD_BITS-1:0] res_min [3],
  output logic signed [COORD_BITS-1:0] res_max [3],
  output logic signed [COORD_BITS-1:0] res_mid [3],
  output logic [COORD_BITS-1:0]        res_radius
);

  localparam int SW   = 2 * COORD_BITS + 2;  // sum of three squares
  localparam int RTW  = COORD_BITS + 1;      // square root of that sum
  localparam int RW   = RTW + 2;             // partial remainder
  localparam int IT_W = $clog2(RTW);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_FINISH
  } state_t;

  state_t                       state;
  logic signed [COORD_BITS-1:0] box_min [3];
  logic signed [COORD_BITS-1:0] box_max [3];
  logic signed [COORD_BITS-1:0] box_mid [3];
  logic [COORD_BITS-1:0]        span [3];
  logic signed [COORD_BITS-1:0] in_min [3];
  logic signed [COORD_BITS-1:0] in_max [3];
  logic signed [COORD_BITS:0]   in_diff [3];
  logic signed [COORD_BITS:0]   in_sum [3];
  logic [COORD_BITS:0]          in_abs [3];
  logic [1:0]                   step;
  logic [COORD_BITS-1:0]        mul_op;
  logic [2*COORD_BITS-1:0]      sq;
  logic [SW-1:0]                prod;
  logic [SW-1:0]                acc;
  logic [IT_W-1:0]              iter;
  logic [RTW-1:0]               root;
  logic [RW-1:0]                rem;
  logic [RW-1:0]                rem_sh;
  logic [RW-1:0]                trial;
  logic                         take;

  // Unpack the queued box; the span per axis is the absolute difference,
  // which always fits the coordinate width as an unsigned value.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      in_min[a]  = q_rdata[a*COORD_BITS +: COORD_BITS];
      in_max[a]  = q_rdata[(a+3)*COORD_BITS +: COORD_BITS];
      in_diff[a] = {in_max[a][COORD_BITS-1], in_max[a]} - {in_min[a][COORD_BITS-1], in_min[a]};
      in_sum[a]  = {in_max[a][COORD_BITS-1], in_max[a]} + {in_min[a][COORD_BITS-1], in_min[a]};
      in_abs[a]  = in_diff[a][COORD_BITS] ? -in_diff[a] : in_diff[a];
    end
  end

  assign q_pop = (state == ST_IDLE) && !q_stat.empty;

  // One shared multiplier squares the three spans in turn.
  always_comb begin
    case (step)
      2'd0:    mul_op = span[0];
      2'd1:    mul_op = span[1];
      default: mul_op = span[2];
    endcase
  end
  assign sq = mul_op * mul_op;

  // Digit-by-digit square root: two radicand bits enter each cycle.
  assign rem_sh = {rem[RW-3:0], acc[SW-1:SW-2]};
  assign trial  = {root, 2'b01};

  // The result register may be refilled when it is empty or being taken.
  assign take = !out_valid || out_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // The result is flagged when the finished box loads and cleared when taken.
      out_valid <= (state == ST_FINISH) || (out_valid && !out_pop);
      unique case (state)
        ST_IDLE: begin
          if (!q_stat.empty) begin
            for (int a = 0; a < 3; a++) begin
              box_min[a] <= in_min[a];
              box_max[a] <= in_max[a];
              box_mid[a] <= in_sum[a][COORD_BITS:1];
              span[a]    <= in_abs[a][COORD_BITS-1:0];
            end
            step  <= 2'd0;
            acc   <= '0;
            state <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          prod <= {2'b00, sq};
          if (step != 2'd0) begin
            acc <= acc + prod;
          end
          step <= step + 2'd1;
          if (step == 2'd3) begin
            rem   <= '0;
            root  <= '0;
            iter  <= '0;
            state <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          acc <= {acc[SW-3:0], 2'b00};
          if (rem_sh >= trial) begin
            rem  <= rem_sh - trial;
            root <= {root[RTW-2:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            root <= {root[RTW-2:0], 1'b0};
          end
          iter <= iter + 1'b1;
          if (iter == IT_W'(RTW - 1)) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (take) begin
            res_min    <= box_min;
            res_max    <= box_max;
            res_mid    <= box_mid;
            res_radius <= root[RTW-1:1];
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/aabb_sphere_accumulator_core.sv
// Top level of the bounding box and bounding sphere accumulator.
//
// Items enter through a queue-style port: a transaction completes when push
// is high and full is low. Each item is a vertex (action low) or a box to
// merge (action high); the item with last_item high closes the run.
// Results leave through a queue-style port: while empty is low the ports
// show the oldest result, and a transaction completes when pop is high.
// Items that do not close a run are taken one per cycle while full is low,
// with no result. A closing item's box is dequeued by the back end, which
// squares and sums the spans on one shared multiplier, takes the square root
// (one result bit a cycle) and then loads the output register. Up to two
// closed boxes wait in the queue, so a new run may be accumulated meanwhile;
// the back end works on one box at a time and dequeues the next only after
// the result of the last has been loaded.
// A receiver that stalls holds the result in place; the back end then waits
// and full rises once the queue fills. Reset empties queue and output and
// marks no run as open; it takes effect at the next clock edge.
module aabb_sphere_accumulator_core #(
  parameter int COORD_BITS = aabb_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic                         action,
  input  logic signed [COORD_BITS-1:0] lo_x,
  input  logic signed [COORD_BITS-1:0] lo_y,
  input  logic signed [COORD_BITS-1:0] lo_z,
  input  logic signed [COORD_BITS-1:0] hi_x,
  input  logic signed [COORD_BITS-1:0] hi_y,
  input  logic signed [COORD_BITS-1:0] hi_z,
  input  logic                         last_item,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [COORD_BITS-1:0] min_x,
  output logic signed [COORD_BITS-1:0] min_y,
  output logic signed [COORD_BITS-1:0] min_z,
  output logic signed [COORD_BITS-1:0] max_x,
  output logic signed [COORD_BITS-1:0] max_y,
  output logic signed [COORD_BITS-1:0] max_z,
  output logic signed [COORD_BITS-1:0] mid_x,
  output logic signed [COORD_BITS-1:0] mid_y,
  output logic signed [COORD_BITS-1:0] mid_z,
  output logic [COORD_BITS-1:0]        radius
);

  localparam int BOX_W = 6 * COORD_BITS;

  logic signed [COORD_BITS-1:0] lo [3];
  logic signed [COORD_BITS-1:0] hi [3];
  logic signed [COORD_BITS-1:0] res_min [3];
  logic signed [COORD_BITS-1:0] res_max [3];
  logic signed [COORD_BITS-1:0] res_mid [3];
  logic                         accept;
  logic                         q_push;
  logic                         q_pop;
  logic [BOX_W-1:0]             q_wdata;
  logic [BOX_W-1:0]             q_rdata;
  aabb_pkg::q_stat_t            q_stat;
  logic                         out_valid;

  assign lo[0] = lo_x;
  assign lo[1] = lo_y;
  assign lo[2] = lo_z;
  assign hi[0] = hi_x;
  assign hi[1] = hi_y;
  assign hi[2] = hi_z;

  // Any item may need a queue slot, so input is held off while it is full.
  assign full   = q_stat.full;
  assign accept = push && !full;

  aabb_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .action    (action),
    .lo        (lo),
    .hi        (hi),
    .last_item (last_item),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  aabb_queue #(
    .WIDTH (BOX_W),
    .DEPTH (aabb_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  aabb_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_stat     (q_stat),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_pop    (pop),
    .out_valid  (out_valid),
    .res_min    (res_min),
    .res_max    (res_max),
    .res_mid    (res_mid),
    .res_radius (radius)
  );

  // Result ports.
  assign empty = !out_valid;
  assign min_x = res_min[0];
  assign min_y = res_min[1];
  assign min_z = res_min[2];
  assign max_x = res_max[0];
  assign max_y = res_max[1];
  assign max_z = res_max[2];
  assign mid_x = res_mid[0];
  assign mid_y = res_mid[1];
  assign mid_z = res_mid[2];

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending right after reset");

  // A closing item is never offered to a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_stat.full))
    else $error("closed box pushed into a full queue");

  // The center of a well-formed box lies within its corners.
  a_mid_inside: assert property (@(posedge clk) disable iff (rst)
    (!empty && (min_x <= max_x)) |-> ((mid_x >= min_x) && (mid_x <= max_x)))
    else $error("center x outside the box");

endmodule

// File: tb/sv/aabb_sphere_accumulator_core_test.sv
// Self-checking testbench for the bounding box and bounding sphere accumulator core.
module aabb_sphere_accumulator_core_test;

  localparam int CB = aabb_pkg::COORD_BITS_DEF;
  // Allowance for a closing item to reach the result port.
  localparam int LATENCY = CB + 7;
  // Cycles without any transaction before the run is declared hung.
  localparam int STALL_LIMIT = 2000;

  // Item kinds carried on the action port.
  localparam logic ACT_VERTEX = 1'b0;
  localparam logic ACT_BOX = 1'b1;

  typedef logic signed [CB-1:0] coord_t;
  // Index 0 is x, 1 is y, 2 is z.
  typedef logic [2:0][CB-1:0] coord_vec_t;
  // Fields 0-2 min, 3-5 max, 6-8 mid (x, y, z), field 9 radius.
  typedef logic [9:0][CB-1:0] box_result_t;

  localparam coord_t COORD_MAX = {1'b0, {(CB-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(CB-1){1'b0}}};

  logic clk;
  logic rst;
  logic push;
  logic full;
  logic action;
  coord_t lo_x, lo_y, lo_z;
  coord_t hi_x, hi_y, hi_z;
  logic last_item;
  logic empty;
  logic pop;
  coord_t min_x, min_y, min_z;
  coord_t max_x, max_y, max_z;
  coord_t mid_x, mid_y, mid_z;
  logic [CB-1:0] radius;

  // Predictor state: running bounds of the open run.
  longint run_min [3];
  longint run_max [3];
  bit run_open = 1'b0;

  box_result_t pending_boxes [$];
  bit idle_on = 1'b1;
  int fail_count = 0;
  int mismatches = 0;

  string field_name [10] = '{"min_x", "min_y", "min_z", "max_x", "max_y", "max_z",
                             "mid_x", "mid_y", "mid_z", "radius"};

  aabb_sphere_accumulator_core #(.COORD_BITS(CB)) DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .action(action),
    .lo_x(lo_x), .lo_y(lo_y), .lo_z(lo_z), .hi_x(hi_x), .hi_y(hi_y), .hi_z(hi_z),
    .last_item(last_item), .empty(empty), .pop(pop),
    .min_x(min_x), .min_y(min_y), .min_z(min_z),
    .max_x(max_x), .max_y(max_y), .max_z(max_z),
    .mid_x(mid_x), .mid_y(mid_y), .mid_z(mid_z), .radius(radius)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic coord_vec_t vec(input int x, input int y, input int z);
    return {coord_t'(z), coord_t'(y), coord_t'(x)};
  endfunction

  // Coordinate source mixing extremes, values near zero and full-range values.
  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return coord_t'(int'($urandom_range(0, 64)) - 32);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Widens the running bounds by one item and, on a closing item, queues the box.
  task automatic update_bounds(input logic act, input coord_vec_t lo, input coord_vec_t hi,
                               input logic last);
    longint lo_v, hi_v, span, mid;
    longint unsigned sq_sum, root, trial;
    box_result_t res;
    sq_sum = 0;
    root = 0;
    for (int a = 0; a < 3; a++) begin
      lo_v = longint'($signed(lo[a]));
      hi_v = (act == ACT_BOX) ? longint'($signed(hi[a])) : lo_v;
      if (!run_open) begin
        run_min[a] = lo_v;
        run_max[a] = hi_v;
      end else begin
        if (lo_v < run_min[a]) run_min[a] = lo_v;
        if (hi_v > run_max[a]) run_max[a] = hi_v;
      end
    end
    run_open = !last;
    if (last) begin
      for (int a = 0; a < 3; a++) begin
        res[a] = run_min[a][CB-1:0];
        res[3+a] = run_max[a][CB-1:0];
        mid = (run_min[a] + run_max[a]) >>> 1;
        res[6+a] = mid[CB-1:0];
        span = (run_max[a] >= run_min[a]) ? run_max[a] - run_min[a] : run_min[a] - run_max[a];
        sq_sum += longint'(span * span);
      end
      // Integer square root, one bit at a time from the top.
      for (int b = CB + 1; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= sq_sum) root = trial;
      end
      res[9] = root[CB:1];
      pending_boxes.push_back(res);
    end
  endtask

  // Offers one item and waits for its transaction, with an optional gap before it.
  task automatic push_item(input logic act, input coord_vec_t lo, input coord_vec_t hi,
                           input logic last);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    push <= 1'b1;
    action <= act;
    lo_x <= lo[0];
    lo_y <= lo[1];
    lo_z <= lo[2];
    hi_x <= hi[0];
    hi_y <= hi[1];
    hi_z <= hi[2];
    last_item <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    update_bounds(act, lo, hi, last);
  endtask

  // Single-item runs at the field extremes; hi fields of vertices must be ignored.
  task automatic test_single_items();
    push_item(ACT_VERTEX, vec(COORD_MAX, COORD_MIN, 0), vec(COORD_MIN, COORD_MAX, -1), 1'b1);
    push_item(ACT_BOX, vec(COORD_MIN, COORD_MIN, COORD_MIN),
              vec(COORD_MAX, COORD_MAX, COORD_MAX), 1'b1);
    push_item(ACT_VERTEX, vec(0, 0, 0), vec(COORD_MAX, COORD_MAX, COORD_MAX), 1'b1);
    push_item(ACT_BOX, vec(-1, 1, COORD_MAX), vec(-1, 1, COORD_MAX), 1'b1);
  endtask

  // Boxes whose minimum lies above their maximum are taken as given.
  task automatic test_inverted_box();
    push_item(ACT_BOX, vec(COORD_MAX, COORD_MAX, COORD_MAX),
              vec(COORD_MIN, COORD_MIN, COORD_MIN), 1'b1);
    push_item(ACT_BOX, vec(5, -7, 100), vec(-5, -9, 3), 1'b1);
    push_item(ACT_VERTEX, vec(0, 0, 0), vec(0, 0, 0), 1'b0);
    push_item(ACT_BOX, vec(20, 20, 20), vec(-20, -20, -20), 1'b1);
  endtask

  // Runs mixing vertices and boxes, then a run that must not inherit old bounds.
  task automatic test_mixed_run();
    push_item(ACT_VERTEX, vec(10, 20, 30), vec(COORD_MIN, COORD_MIN, COORD_MIN), 1'b0);
    push_item(ACT_BOX, vec(-100, 5, 40), vec(50, 25, 35), 1'b0);
    push_item(ACT_VERTEX, vec(-1, -1, -1), vec(COORD_MAX, 0, 0), 1'b0);
    push_item(ACT_VERTEX, vec(7, 7, 7), vec(0, 0, 0), 1'b1);
    push_item(ACT_VERTEX, vec(1000, 1000, 1000), vec(0, 0, 0), 1'b0);
    push_item(ACT_VERTEX, vec(1001, 999, 1000), vec(0, 0, 0), 1'b1);
  endtask

  // Center sums that are odd and negative round toward minus infinity.
  task automatic test_center_rounding();
    push_item(ACT_VERTEX, vec(-3, -3, -3), vec(0, 0, 0), 1'b0);
    push_item(ACT_VERTEX, vec(0, 0, 0), vec(0, 0, 0), 1'b1);
    push_item(ACT_BOX, vec(COORD_MIN, COORD_MIN, -1), vec(-1, COORD_MAX, 0), 1'b1);
    push_item(ACT_BOX, vec(COORD_MIN, 3, -5), vec(COORD_MIN, 4, -2), 1'b1);
  endtask

  // Random runs: mostly short, sometimes long, with ordered and inverted boxes.
  task automatic random_runs(input int n_items);
    int sent;
    int len;
    logic act;
    coord_vec_t lo, hi;
    coord_t tmp;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        act = $urandom_range(0, 1) ? ACT_BOX : ACT_VERTEX;
        for (int a = 0; a < 3; a++) begin
          lo[a] = rand_coord();
          hi[a] = rand_coord();
          // Most boxes are well ordered; the rest stay inverted.
          if (act == ACT_BOX && $signed(lo[a]) > $signed(hi[a]) &&
              $urandom_range(0, 3) != 0) begin
            tmp = lo[a];
            lo[a] = hi[a];
            hi[a] = tmp;
          end
        end
        push_item(act, lo, hi, i == len - 1);
      end
      sent += len;
    end
  endtask

  task automatic test_random_runs();
    random_runs(1200);
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_streaming_runs();
    idle_on = 1'b0;
    random_runs(350);
  endtask

  // Result receiver: pops with random stall bursts while idling is enabled.
  initial begin : result_drain
    int stall_len;
    pop = 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_len = $urandom_range(1, 15);
        pop <= 1'b0;
        repeat (stall_len - 1) @(posedge clk);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Compares every result transaction with the oldest expected box.
  initial begin : result_checker
    box_result_t got, want;
    int bad_field;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        got = {radius, mid_z, mid_y, mid_x, max_z, max_y, max_x, min_z, min_y, min_x};
        if (pending_boxes.size() == 0) begin
          fail_count++;
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transaction: %h", got);
        end else begin
          want = pending_boxes.pop_front();
          if (got !== want) begin
            fail_count++;
            mismatches++;
            bad_field = 0;
            for (int f = 9; f >= 0; f--) begin
              if (got[f] !== want[f]) bad_field = f;
            end
            if (mismatches <= 10) begin
              $display("mismatch on %s: expected %h got %h (box expected %h got %h)",
                       field_name[bad_field], want[bad_field], got[bad_field], want, got);
            end
          end
        end
      end
    end
  end

  // Watchdog: ends the run when no transaction happens for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Test sequence.
  initial begin
    rst = 1'b1;
    push = 1'b0;
    action = ACT_VERTEX;
    lo_x = '0;
    lo_y = '0;
    lo_z = '0;
    hi_x = '0;
    hi_y = '0;
    hi_z = '0;
    last_item = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_single_items();
    test_inverted_box();
    test_mixed_run();
    test_center_rounding();
    test_random_runs();
    test_streaming_runs();
    push <= 1'b0;

    // Drain outstanding boxes, then watch for stray results.
    while (pending_boxes.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/aabb_pkg.sv
hdl/aabb_front.sv
hdl/aabb_queue.sv
hdl/aabb_back.sv
hdl/aabb_sphere_accumulator_core.sv
tb/sv/aabb_sphere_accumulator_core_test.sv
